@@ rtl/core/sha_pkg.sv @@
// SHA-256 stream hasher: shared types, constants and a rotate function.
// No dependencies.
package sha_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_t;

  typedef logic [31:0] word_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam word_t H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic start;   // load working vars from chain, begin rounds
    logic step;    // perform one round
    logic fold;    // add working vars into chain
    logic init;    // restore initial hash
  } rnd_ctrl_t;

  function automatic word_t ror(word_t x, int n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

endpackage

@@ rtl/core/sha_round.sv @@
// SHA-256 round datapath: one shared round unit, schedule window, chain.
// Depends on sha_pkg.
module sha_round import sha_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  rnd_ctrl_t  ctrl,
  input  logic [5:0] rnd,
  input  logic       wr_en,
  input  logic [3:0] wr_idx,
  input  word_t      wr_data,
  output word_t      win [16],
  output word_t      chain [8]
);

  word_t w_r [16];
  word_t v_r [8];
  word_t h_r [8];
  word_t w_t, s0, s1, t1, t2;

  always_comb begin
    s1 = ror(w_r[4'(rnd - 6'd2)], 17) ^ ror(w_r[4'(rnd - 6'd2)], 19)
       ^ (w_r[4'(rnd - 6'd2)] >> 10);
    s0 = ror(w_r[4'(rnd - 6'd15)], 7) ^ ror(w_r[4'(rnd - 6'd15)], 18)
       ^ (w_r[4'(rnd - 6'd15)] >> 3);
    if (rnd < 6'd16) w_t = w_r[rnd[3:0]];
    else w_t = s1 + w_r[4'(rnd - 6'd7)] + s0 + w_r[rnd[3:0]];
    t1 = v_r[7] + (ror(v_r[4], 6) ^ ror(v_r[4], 11) ^ ror(v_r[4], 25))
       + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) + K_TAB[rnd] + w_t;
    t2 = (ror(v_r[0], 2) ^ ror(v_r[0], 13) ^ ror(v_r[0], 22))
       + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  always_ff @(posedge clk) begin
    if (wr_en) w_r[wr_idx] <= wr_data;
    else if (ctrl.step) w_r[rnd[3:0]] <= w_t;
    if (ctrl.start) v_r <= h_r;
    else if (ctrl.step) begin
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.init) h_r <= H_INIT;
    else if (ctrl.fold) begin
      for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
    end
  end

  assign win = w_r;
  assign chain = h_r;

endmodule

@@ rtl/core/sha256_stream_hasher_core.sv @@
// SHA-256 stream hasher top level: byte packing, padding sequencer, output.
// Depends on sha_pkg and sha_round.
//
//  channel | dir | tdata                       | tuser / tlast
//  in_     | in  | [7:0] data_byte             | tuser byte_valid, tlast end_of_message
//  out_    | out | [31:0] digest_word, [34:32] word_index | tlast last_word
//
// A byte that does not fill a block is accepted while idle. A byte completing a
// block starts load, 64 rounds of the shared round unit and fold; in_tready is low.
// A message end pads through to byte 63, compresses one or two blocks,
// then streams eight words; out_tvalid holds until each transfer.
// Reset (rst_n low, synchronous) restores the initial hash and clears counters.
module sha256_stream_hasher_core import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // byte_valid
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] digest_word, [34:32] word_index, zeros
  output logic        out_tlast   // last_word
);

  state_t     state_r, state_nxt;
  logic [5:0] fill_r;
  logic [63:0] len_r;
  logic [5:0] rnd_r;
  logic       fin_r;     // message end in progress
  logic       lenok_r;   // length goes into the block being padded
  logic       mark_r;    // 0x80 marker already placed
  logic [2:0] oidx_r;
  rnd_ctrl_t  ctrl;
  logic       wr_en;
  logic [3:0] wr_idx;
  word_t      wr_data;
  word_t      win [16];
  word_t      chain [8];
  logic [7:0] pbyte;
  logic [1:0] bsel;
  logic       acc;

  sha_round u_round (
    .clk, .rst_n, .ctrl, .rnd(rnd_r), .wr_en, .wr_idx, .wr_data,
    .win, .chain
  );

  assign acc = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);

  // byte insertion into the schedule window
  always_comb begin
    pbyte = in_tdata;
    bsel = fill_r[1:0];
    wr_idx = fill_r[5:2];
    wr_data = win[wr_idx];
    wr_en = 1'b0;
    if (state_r == ST_IDLE) begin
      wr_en = acc && in_tuser;
    end else if (state_r == ST_PAD) begin
      wr_en = 1'b1;
      if (!mark_r) pbyte = PAD_BYTE;
      else if (lenok_r && fill_r[5:3] == 3'd7) pbyte = 8'(len_r >> {~fill_r[2:0], 3'b000});
      else pbyte = 8'h00;
    end
    unique case (bsel)
      2'd0: wr_data = {pbyte, wr_data[23:0]};
      2'd1: wr_data = {wr_data[31:24], pbyte, wr_data[15:0]};
      2'd2: wr_data = {wr_data[31:16], pbyte, wr_data[7:0]};
      2'd3: wr_data = {wr_data[31:8], pbyte};
      default: wr_data = wr_data;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (acc) begin
        if (in_tuser && fill_r == 6'd63) state_nxt = ST_ROUND;
        else if (in_tlast) state_nxt = ST_PAD;
      end
      ST_PAD: if (fill_r == 6'd63) state_nxt = ST_ROUND;
      ST_ROUND: if (rnd_r == 6'd63) state_nxt = ST_FOLD;
      ST_FOLD: begin
        if (!fin_r) state_nxt = ST_IDLE;
        else if (lenok_r) state_nxt = ST_EMIT;
        else state_nxt = ST_PAD;
      end
      ST_EMIT: if (out_tready && oidx_r == 3'd7) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    ctrl.start = (state_nxt == ST_ROUND) && (state_r != ST_ROUND);
    ctrl.step  = (state_r == ST_ROUND);
    ctrl.fold  = (state_r == ST_FOLD);
    ctrl.init  = (state_r == ST_EMIT) && out_tready && (oidx_r == 3'd7);
  end

  // The pad state sweeps from the fill position to 63: the marker first (unless
  // already placed), then zeros; when the length fits, bytes 56..63 take the bit length.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r <= '0;
      len_r <= '0;
      rnd_r <= '0;
      fin_r <= 1'b0;
      lenok_r <= 1'b0;
      mark_r <= 1'b0;
      oidx_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_ROUND) rnd_r <= rnd_r + 6'd1;
      unique case (state_r)
        ST_IDLE: if (acc) begin
          if (in_tuser) begin
            len_r <= len_r + 64'd8;
            fill_r <= fill_r + 6'd1;
          end
          if (in_tlast) fin_r <= 1'b1;
        end
        ST_PAD: begin
          fill_r <= fill_r + 6'd1;
          if (!mark_r) begin
            mark_r <= 1'b1;
            lenok_r <= (fill_r < 6'd56);
          end
        end
        ST_FOLD: if (fin_r && !lenok_r) lenok_r <= 1'b1;
        ST_EMIT: if (out_tready) begin
          oidx_r <= oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            fin_r <= 1'b0; lenok_r <= 1'b0; mark_r <= 1'b0;
            len_r <= '0; fill_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = (state_r == ST_EMIT);
  assign out_tdata = {5'd0, oidx_r, chain[oidx_r]};
  assign out_tlast = (oidx_r == 3'd7);

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) |-> !in_tready) else $error("ready during rounds");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (state_r == ST_IDLE))
    else $error("no idle after digest");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid) else $error("digest dropped");

endmodule

@@ sim/sha256_stream_hasher_core_tb.sv @@
// Self-checking bench for sha256_stream_hasher_core: streams byte messages,
// predicts each SHA-256 digest in SystemVerilog, and checks every word sent back.
// Depends on sha_pkg and the core RTL.
module sha256_stream_hasher_core_tb import sha_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } byte_item_t;

  typedef struct packed {
    word_t      digest_word;
    logic [2:0] word_index;
    logic       last_word;
  } digest_beat_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        out_tlast;

  sha256_stream_hasher_core dut (.*);

  byte_item_t   pending_bytes[$];
  digest_beat_t expected_digest[$];

  // predictor state
  word_t       chain_h[8];
  logic [7:0]  msg_block[64];
  int          fill_cnt;
  logic [63:0] msg_bits;

  int  fail_cnt = 0;
  bit  stim_done = 0;
  bit  calm = 0;
  int  in_gap = 0;
  int  out_gap = 0;
  int  idle_cycles = 0;

  function automatic word_t rotr(word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic hash_block();
    word_t w[64];
    word_t a, b, c, d, e, f, g, h, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
           + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    {a, b, c, d, e, f, g, h} = {chain_h[0], chain_h[1], chain_h[2], chain_h[3],
                                chain_h[4], chain_h[5], chain_h[6], chain_h[7]};
    for (int i = 0; i < 64; i++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + K_TAB[i] + w[i];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
    chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
  endtask

  task automatic restart_digest();
    for (int i = 0; i < 8; i++) chain_h[i] = H_INIT[i];
    fill_cnt = 0;
    msg_bits = '0;
  endtask

  task automatic predict_digest(byte_item_t it);
    digest_beat_t beat;
    if (it.byte_valid) begin
      msg_block[fill_cnt] = it.data_byte;
      msg_bits += 64'd8;
      fill_cnt++;
      if (fill_cnt == 64) begin
        hash_block();
        fill_cnt = 0;
      end
    end
    if (!it.end_of_message) return;
    msg_block[fill_cnt] = PAD_BYTE;
    for (int p = fill_cnt + 1; p < 64; p++) msg_block[p] = 8'h00;
    if (fill_cnt + 1 > 56) begin
      hash_block();
      for (int p = 0; p < 64; p++) msg_block[p] = 8'h00;
    end
    for (int i = 0; i < 8; i++) msg_block[56 + i] = msg_bits[63 - 8*i -: 8];
    hash_block();
    for (int i = 0; i < 8; i++) begin
      beat.digest_word = chain_h[i];
      beat.word_index  = i[2:0];
      beat.last_word   = (i == 7);
      expected_digest.push_back(beat);
    end
    restart_digest();
  endtask

  task automatic add_message(int len, bit bare_end);
    byte_item_t it;
    for (int i = 0; i < len; i++) begin
      it.data_byte      = 8'($urandom_range(0, 255));
      it.byte_valid     = 1'b1;
      it.end_of_message = !bare_end && (i == len - 1);
      // sprinkle ignored items
      if ($urandom_range(0, 29) == 0)
        pending_bytes.push_back('{data_byte: 8'($urandom_range(0, 255)), byte_valid: 1'b0,
                                  end_of_message: 1'b0});
      pending_bytes.push_back(it);
    end
    if (bare_end || len == 0)
      pending_bytes.push_back('{data_byte: 8'($urandom_range(0, 255)), byte_valid: 1'b0,
                                end_of_message: 1'b1});
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    int sent;
    restart_digest();
    // directed: empty message, extreme bytes, ignored item, block-boundary lengths
    add_message(0, 1'b1);
    pending_bytes.push_back('{data_byte: 8'hff, byte_valid: 1'b0, end_of_message: 1'b0});
    pending_bytes.push_back('{data_byte: 8'h00, byte_valid: 1'b1, end_of_message: 1'b0});
    pending_bytes.push_back('{data_byte: 8'hff, byte_valid: 1'b1, end_of_message: 1'b1});
    add_message(55, 1'b0);   // length fits in the same block
    add_message(56, 1'b1);   // needs a second padding block
    add_message(64, 1'b0);   // block fills on the last byte
    add_message(64, 1'b1);
    add_message(63, 1'b0);
    sent = 0;
    foreach (pending_bytes[i]) sent++;
    while (sent < 430) begin
      int len;
      int before_n;
      before_n = pending_bytes.size();
      case ($urandom_range(0, 3))
        0: len = $urandom_range(0, 8);
        1: len = $urandom_range(52, 70);
        default: len = $urandom_range(0, 140);
      endcase
      add_message(len, $urandom_range(0, 1));
      sent += pending_bytes.size() - before_n;
    end
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= 1'b0;
      in_tlast  <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) predict_digest('{in_tdata, in_tuser, in_tlast});
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        byte_item_t it;
        it = pending_bytes.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= it.data_byte;
        in_tuser  <= it.byte_valid;
        in_tlast  <= it.end_of_message;
        calm <= pending_bytes.size() < 120;
        if (!calm && $urandom_range(0, 9) == 0) in_gap <= $urandom_range(1, 13);
      end else begin
        in_tvalid <= 1'b0;
        stim_done <= 1'b1;
      end
    end
  end

  // monitor and sink stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        digest_beat_t got, want;
        got = '{out_tdata[31:0], out_tdata[34:32], out_tlast};
        if (expected_digest.size() == 0) begin
          $error("unexpected digest word %h", got.digest_word);
          fail_cnt++;
        end else begin
          want = expected_digest.pop_front();
          if (got.digest_word !== want.digest_word) begin
            $error("digest_word: expected %h, got %h", want.digest_word, got.digest_word);
            fail_cnt++;
          end
          if (got.word_index !== want.word_index) begin
            $error("word_index: expected %0d, got %0d", want.word_index, got.word_index);
            fail_cnt++;
          end
          if (got.last_word !== want.last_word) begin
            $error("last_word: expected %0d, got %0d", want.last_word, got.last_word);
            fail_cnt++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_gap <= $urandom_range(1, 13) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog and end of run
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done && expected_digest.size() == 0);
    repeat (300) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/sha_pkg.sv
rtl/core/sha_round.sv
rtl/core/sha256_stream_hasher_core.sv
sim/sha256_stream_hasher_core_tb.sv
